@@ src/mie_pkg.sv @@
// Package for the extended Euclidean modular inverse block.
// Holds the data width, the beat types, the sequencer step codes and the microcode table.
// No dependencies.
`timescale 1ns / 1ps

package mie_pkg;

    // Width of value, modulus, inverse and divisor.
    localparam int DATA_WIDTH = 32;
    // Coefficients are signed and stay within plus or minus twice the modulus.
    localparam int COEF_WIDTH = DATA_WIDTH + 2;
    // The division loop counter counts from DATA_WIDTH - 1 down to zero.
    localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [DATA_WIDTH-1:0] modulus;
    } operand_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] inverse;
        logic [DATA_WIDTH-1:0] divisor;
    } result_t;

    // Program steps, which are also the addresses of the microcode table.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_FOLD,
        ST_UPDATE,
        ST_FINISH
    } step_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_REM_ZERO,
        C_CNT_NZ
    } cond_t;

    // One control word of the program.
    typedef struct packed {
        logic  load;
        logic  div_init;
        logic  div_step;
        logic  fold;
        logic  update;
        logic  done;
        logic  cnt_load;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Status from the datapath that the jump conditions test.
    typedef struct packed {
        logic start;
        logic rem_zero;
    } seq_flags_t;

    function automatic ctrl_t rom_word(input step_t step);
        ctrl_t w;
        w = '0;
        case (step)
            ST_IDLE:
            begin
                w.load   = 1'b1;
                w.cond   = C_NO_START;
                w.target = ST_IDLE;
            end
            ST_TEST:
            begin
                w.cond   = C_REM_ZERO;
                w.target = ST_FINISH;
            end
            ST_DIV_INIT:
            begin
                w.div_init = 1'b1;
                w.cnt_load = 1'b1;
                w.cond     = C_NEVER;
                w.target   = ST_IDLE;
            end
            ST_DIV_STEP:
            begin
                w.div_step = 1'b1;
                w.cond     = C_CNT_NZ;
                w.target   = ST_DIV_STEP;
            end
            ST_FOLD:
            begin
                w.fold   = 1'b1;
                w.cond   = C_NEVER;
                w.target = ST_IDLE;
            end
            ST_UPDATE:
            begin
                w.update = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = ST_TEST;
            end
            ST_FINISH:
            begin
                w.done   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/mie_seq.sv @@
// Microcode sequencer: step counter, division loop counter and the control table lookup.
// Depends on mie_pkg for the step codes, jump conditions and the table.
`timescale 1ns / 1ps

module mie_seq
    import mie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_t      ctrl,
    output logic       busy
);

    step_t                pc_reg;
    step_t                pc_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    ctrl_t                word;
    logic                 take;

    assign word = rom_word(pc_reg);

    // Next step and loop counter.
    always_comb
    begin
        case (word.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = ~flags.start;
            C_REM_ZERO: take = flags.rem_zero;
            C_CNT_NZ:   take = (cnt_reg != '0);
            default:    take = 1'b0;
        endcase

        if (take)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = step_t'(3'(pc_reg + 3'd1));
        end

        cnt_next = cnt_reg;
        if (word.cnt_load)
        begin
            cnt_next = CNT_WIDTH'(DATA_WIDTH - 1);
        end
        else if (word.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Outputs.
    always_comb
    begin
        ctrl = word;
        busy = (pc_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/modular_inverse_ext_euclid.sv @@
// Top level of the extended Euclidean modular inverse block: datapath and output register.
// Depends on mie_pkg and on the sequencer mie_seq.
`timescale 1ns / 1ps

// A beat is accepted when start is high while busy is low; busy then stays high until the
// result is ready. The result beat (inverse and divisor) appears on result for exactly one
// cycle with done high, and the receiver cannot stall it, so it must take the beat in that
// cycle. Each Euclid iteration runs a test of the remainder, a divider setup, a one-bit-per-cycle
// restoring divider that also builds the product of quotient and coefficient bit by bit, a
// step that folds in the last quotient bit and a step that updates the remainders and
// coefficients. A new beat can be accepted in the cycle that done is shown. For 32 bits
// the iteration count is at most 46 (a pair of consecutive Fibonacci numbers, plus one
// step when value is below the modulus); a zero modulus goes from the remainder test
// straight to the finish step. A divisor of one means inverse is the modular inverse of
// value; otherwise no inverse exists. A zero modulus returns inverse 1 and divisor equal
// to value.
module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  operand_t operand,
    output logic     done,
    output result_t  result
);

    localparam int W = DATA_WIDTH;

    ctrl_t      ctrl;
    seq_flags_t flags;

    // Remainder pair, original modulus and the two Bezout coefficients of value.
    logic [W-1:0]          rem_hi_reg, rem_hi_next;
    logic [W-1:0]          rem_lo_reg, rem_lo_next;
    logic [W-1:0]          mod_reg, mod_next;
    logic [COEF_WIDTH-1:0] cp_reg, cp_next;
    logic [COEF_WIDTH-1:0] cc_reg, cc_next;

    // Divider: partial remainder, dividend shift register, last quotient bit, and the
    // running product of quotient and current coefficient.
    logic [W-1:0]          pr_reg, pr_next;
    logic [W-1:0]          dv_reg, dv_next;
    logic                  qbit_reg, qbit_next;
    logic [COEF_WIDTH-1:0] prod_reg, prod_next;

    result_t               result_reg, result_next;
    logic                  done_reg, done_next;

    logic [W:0]            trial;
    logic [W+1:0]          diff;
    logic                  fits;
    logic [COEF_WIDTH-1:0] prod_acc;
    logic [COEF_WIDTH-1:0] coef_adj;

    assign flags.start    = start;
    assign flags.rem_zero = (rem_lo_reg == '0);

    mie_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // One restoring division step: bring down the next dividend bit and subtract the
    // divisor when it fits.
    assign trial = {pr_reg, dv_reg[W-1]};
    assign diff  = {1'b0, trial} - {2'b00, rem_lo_reg};
    assign fits  = ~diff[W+1];

    // The product is built most significant quotient bit first from the divider's registered
    // quotient bit, so each cycle holds only a shift and one add.
    assign prod_acc = {prod_reg[COEF_WIDTH-2:0], 1'b0} + (qbit_reg ? cc_reg : '0);

    // A negative coefficient is brought into range by adding the modulus.
    assign coef_adj = cp_reg[COEF_WIDTH-1] ? (cp_reg + COEF_WIDTH'(mod_reg)) : cp_reg;

    always_comb
    begin
        rem_hi_next = rem_hi_reg;
        rem_lo_next = rem_lo_reg;
        mod_next    = mod_reg;
        cp_next     = cp_reg;
        cc_next     = cc_reg;
        pr_next     = pr_reg;
        dv_next     = dv_reg;
        qbit_next   = qbit_reg;
        prod_next   = prod_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        if (ctrl.load && start)
        begin
            rem_hi_next = operand.value;
            rem_lo_next = operand.modulus;
            mod_next    = operand.modulus;
            cp_next     = COEF_WIDTH'(1);
            cc_next     = '0;
        end

        if (ctrl.div_init)
        begin
            pr_next   = '0;
            dv_next   = rem_hi_reg;
            qbit_next = 1'b0;
            prod_next = '0;
        end

        if (ctrl.div_step)
        begin
            pr_next   = fits ? diff[W-1:0] : trial[W-1:0];
            dv_next   = {dv_reg[W-2:0], 1'b0};
            qbit_next = fits;
            prod_next = prod_acc;
        end

        if (ctrl.fold)
        begin
            prod_next = prod_acc;
        end

        if (ctrl.update)
        begin
            cc_next     = cp_reg - prod_reg;
            cp_next     = cc_reg;
            rem_hi_next = rem_lo_reg;
            rem_lo_next = pr_reg;
        end

        if (ctrl.done)
        begin
            result_next.inverse = coef_adj[W-1:0];
            result_next.divisor = rem_hi_reg;
            done_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_hi_reg <= rem_hi_next;
        rem_lo_reg <= rem_lo_next;
        mod_reg    <= mod_next;
        cp_reg     <= cp_next;
        cc_reg     <= cc_next;
        pr_reg     <= pr_next;
        dv_reg     <= dv_next;
        qbit_reg   <= qbit_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/mie_checker.sv @@
// Port-level checker for the modular inverse block, bound to its top level.
// Depends on mie_pkg and on modular_inverse_ext_euclid.
`timescale 1ns / 1ps

module mie_checker
    import mie_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input operand_t operand,
    input logic     done,
    input result_t  result
);

    // A result beat is only shown once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done seen while busy");

    // An accepted beat makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Each result beat lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Finishing an item always delivers its result.
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result beat");

    // Accepted operands and shown results carry no unknown bits.
    a_beats_known: assert property (@(posedge clk) disable iff (!rst_n)
        !((done && $isunknown(result)) || (start && !busy && $isunknown(operand))))
        else $error("unknown bits in an accepted operand or a result beat");

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the extended Euclidean modular inverse block.
// Depends on mie_pkg and on modular_inverse_ext_euclid with its sequencer.
`timescale 1ns / 1ps

module tb;

    import mie_pkg::*;

    // The clock period is 10 ns. Every input changes at the falling edge. Every output is
    // sampled at the rising edge, so the testbench always sees settled values there.
    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    operand_t operand = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // The checker pops the oldest entry each time a result beat shows up.
    result_t expected_results[$];

    int beats_sent      = 0;
    int results_checked = 0;
    int fail_count      = 0;
    // Chance, in percent, that the sender waits before each beat; it draws again after every wait.
    int sender_idle_pct = 0;

    modular_inverse_ext_euclid i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Independent model of the block. The remainder pair runs down as in the textbook
    // algorithm, and only the coefficient of value is tracked. The coefficient is a signed
    // number kept as 64-bit two's complement, and products wrap in the same way. A negative
    // final coefficient is lifted by one modulus. With a zero modulus the loop never runs,
    // so the coefficient stays 1 and the divisor is the value itself.
    function automatic result_t predict_inverse(input operand_t op);
        logic [63:0] rem_a;
        logic [63:0] rem_b;
        logic [63:0] quo;
        logic [63:0] rem_next;
        logic [63:0] coef_old;
        logic [63:0] coef_new;
        logic [63:0] coef_tmp;
        result_t     res;
        rem_a    = 64'(op.value);
        rem_b    = 64'(op.modulus);
        coef_old = 64'd1;
        coef_new = 64'd0;
        while (rem_b != 64'd0)
        begin
            quo      = rem_a / rem_b;
            rem_next = rem_a % rem_b;
            coef_tmp = coef_old - quo * coef_new;
            coef_old = coef_new;
            coef_new = coef_tmp;
            rem_a    = rem_b;
            rem_b    = rem_next;
        end
        if (coef_old[63])
        begin
            coef_old = coef_old + 64'(op.modulus);
        end
        res.inverse = coef_old[DATA_WIDTH-1:0];
        res.divisor = rem_a[DATA_WIDTH-1:0];
        return res;
    endfunction

    // Sends one operand beat. The task is entered and left at a falling edge. It leaves
    // start high, so back-to-back beats keep start high without a glitch; the next call
    // either drives the next beat or drops start while idling.
    task automatic send_operand(input logic [DATA_WIDTH-1:0] val,
                                input logic [DATA_WIDTH-1:0] modv);
        operand_t op;
        op.value   = val;
        op.modulus = modv;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        operand <= op;
        // The beat is taken at the first rising edge where busy is low.
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_results.push_back(predict_inverse(op));
        beats_sent++;
        @(negedge clk);
    endtask

    // Holds start low until every outstanding result has been checked.
    task automatic wait_results_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Picks an operand pair from a weighted mix. Plain random pairs exercise the long
    // division paths. The other kinds aim at the corner cases: shared factors, exact
    // multiples, zero fields, a unit modulus, small moduli and pairs with the top bit set.
    task automatic random_operand(output logic [DATA_WIDTH-1:0] val,
                                  output logic [DATA_WIDTH-1:0] modv);
        int          kind;
        logic [31:0] factor;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            val  = DATA_WIDTH'($urandom());
            modv = DATA_WIDTH'($urandom());
        end
        else if (kind < 55)
        begin
            val  = DATA_WIDTH'($urandom());
            modv = DATA_WIDTH'($urandom_range(2, 1000));
        end
        else if (kind < 65)
        begin
            // Common factor, so the divisor is above one.
            factor = $urandom_range(2, 50);
            val    = DATA_WIDTH'($urandom_range(1, 1 << 26) * factor);
            modv   = DATA_WIDTH'($urandom_range(1, 1 << 26) * factor);
        end
        else if (kind < 72)
        begin
            modv = DATA_WIDTH'($urandom_range(1, 65535));
            val  = DATA_WIDTH'(modv * $urandom_range(0, 65535));
        end
        else if (kind < 77)
        begin
            val  = DATA_WIDTH'($urandom());
            modv = '0;
        end
        else if (kind < 82)
        begin
            val  = '0;
            modv = DATA_WIDTH'($urandom());
        end
        else if (kind < 85)
        begin
            val  = DATA_WIDTH'($urandom());
            modv = DATA_WIDTH'(1);
        end
        else if (kind < 92)
        begin
            val  = DATA_WIDTH'($urandom());
            modv = DATA_WIDTH'($urandom() | 32'h8000_0001);
        end
        else
        begin
            val  = DATA_WIDTH'($urandom() | 32'h8000_0000);
            modv = DATA_WIDTH'($urandom() | 32'h8000_0000);
        end
    endtask

    // Field extremes and the all-zero and all-one patterns.
    task automatic test_field_extremes();
        send_operand('0, '0);
        send_operand('1, '0);
        send_operand('0, '1);
        send_operand('1, '1);
        send_operand(DATA_WIDTH'(1), '1);
        send_operand('1, DATA_WIDTH'(32'hFFFF_FFFE));
        send_operand(DATA_WIDTH'(32'h8000_0000), '1);
        send_operand(DATA_WIDTH'(1), DATA_WIDTH'(1));
    endtask

    // Each special case of the algorithm once or twice.
    task automatic test_special_cases();
        // Zero modulus returns coefficient one and the value as divisor.
        send_operand(DATA_WIDTH'(32'h1234_5678), '0);
        // Zero value with a nonzero modulus.
        send_operand('0, DATA_WIDTH'(97));
        // Unit modulus.
        send_operand(DATA_WIDTH'(12345), DATA_WIDTH'(1));
        send_operand('1, DATA_WIDTH'(1));
        // Value an exact multiple of the modulus.
        send_operand(DATA_WIDTH'(100), DATA_WIDTH'(10));
        send_operand(DATA_WIDTH'(32'hAAAA_AAAA), DATA_WIDTH'(32'h5555_5555));
        // Divisor above one: the reduced coefficient still comes back.
        send_operand(DATA_WIDTH'(6), DATA_WIDTH'(9));
        send_operand(DATA_WIDTH'(32'hFFFF_FFFE), DATA_WIDTH'(32'h8000_0000));
        // Ordinary inverses, value below and above the modulus.
        send_operand(DATA_WIDTH'(3), DATA_WIDTH'(7));
        send_operand(DATA_WIDTH'(17), DATA_WIDTH'(5));
        // Consecutive Fibonacci numbers give the longest chain of iterations.
        send_operand(DATA_WIDTH'(32'd1836311903), DATA_WIDTH'(32'd2971215073));
        send_operand(DATA_WIDTH'(32'd2971215073), DATA_WIDTH'(32'd1836311903));
    endtask

    // The sender stops until the block has answered everything, then restarts with
    // back-to-back beats, so the block is seen both fully quiet and under load.
    task automatic test_pause_until_empty();
        logic [DATA_WIDTH-1:0] val;
        logic [DATA_WIDTH-1:0] modv;
        sender_idle_pct = 0;
        repeat (2)
        begin
            repeat (3)
            begin
                random_operand(val, modv);
                send_operand(val, modv);
            end
            wait_results_drained();
        end
    endtask

    // A stretch of random beats with the given sender idle rate.
    task automatic test_random_operands(input int count, input int idle_pct);
        logic [DATA_WIDTH-1:0] val;
        logic [DATA_WIDTH-1:0] modv;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            random_operand(val, modv);
            send_operand(val, modv);
        end
    endtask

    // Result checker. The receiver cannot stall, so every rising edge with done high
    // carries one result beat that must match the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no prediction waiting: inverse %0h divisor %0h",
                       result.inverse, result.divisor);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.inverse !== want.inverse)
                begin
                    $error("inverse: expected %0h, actual %0h", want.inverse, result.inverse);
                    fail_count++;
                end
                if (result.divisor !== want.divisor)
                begin
                    $error("divisor: expected %0h, actual %0h", want.divisor, result.divisor);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    // Main sequence: reset once, directed beats, then random beats under three idle rates.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_special_cases();
        test_pause_until_empty();
        test_random_operands(130, 25);
        test_random_operands(130, 77);
        test_random_operands(130, 0);

        wait_results_drained();
        // Extra cycles afterwards catch any stray result beat.
        repeat (4 * (DATA_WIDTH + 4)) @(posedge clk);

        $display("Sent %0d operand beats: field extremes, zero and unit moduli, multiples,",
                 beats_sent);
        $display("shared factors, Fibonacci pairs, random mixes at three idle rates; %0d checked",
                 results_checked);
        if (fail_count == 0)
        begin
            $display("[modular_inverse_ext_euclid] OK");
        end
        else
        begin
            $display("[modular_inverse_ext_euclid] ERROR");
        end
        $finish;
    end

    // Watchdog. The slowest correct run is near 420 beats of the longest kind plus sender
    // gaps, about 7 ms of 10 ns cycles; 50 ms leaves a wide margin.
    initial
    begin
        #50_000_000;
        $display("[modular_inverse_ext_euclid] ERROR");
        $finish;
    end

endmodule

@@ modular_inverse_ext_euclid.f @@
src/mie_pkg.sv
src/mie_seq.sv
src/modular_inverse_ext_euclid.sv
src/mie_checker.sv
tb/tb.sv
